// File: src/ivt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer package
// Shared action codes and stream layout constants for the interval timer.
// ----------------------------------------------------------------------------
package ivt_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    localparam int ACTION_W = 3;
    localparam int MS_W     = 32;

    localparam int ACTION_LSB = 0;
    localparam int NOW_LSB    = ACTION_LSB + ACTION_W;
    localparam int DELAY_LSB  = NOW_LSB + MS_W;

    localparam int FIRED_BIT   = 0;
    localparam int EXPIRED_BIT = 1;
    localparam int RUNNING_BIT = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_START   = 3'd1,
        ACT_RESTART = 3'd2,
        ACT_CANCEL  = 3'd3,
        ACT_POLL    = 3'd4
    } t_action;

endpackage
`default_nettype wire

// File: src/interval_timer_with_wrap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer with wrap
// One-shot or periodic millisecond timer that handles wrap of the time base.
// ----------------------------------------------------------------------------
// Each item carries the current time and an action (tick, start, restart,
// cancel, poll) and produces one result item with the fired, expired and
// running flags. The block takes one item per clock cycle while the output
// is not stalled. An accepted item passes an input register, then one pass
// of add and compare logic that updates the timer state and fills the output
// register. The state update of one item is written with its result, so the
// next item sees it at once. The input side is not ready while reset is
// held. A write of the recurring bit takes effect at every edge with the
// write enable high; write it only while no item is in flight.
module interval_timer_with_wrap #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // action [2:0], now_ms [34:3], delay_ms [66:35], zeros above
    input  wire logic [ivt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // fired [0], expired [1], running [2], zeros above
    output logic [ivt_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    logic                        r_recurring;

    logic                        r_in_valid;
    ivt_pkg::t_action            r_action;
    logic [ivt_pkg::MS_W-1:0]    r_now_ms;
    logic [ivt_pkg::MS_W-1:0]    r_delay_ms;

    logic [TIME_WIDTH-1:0]       r_interval_len;
    logic [TIME_WIDTH-1:0]       r_trigger_time;
    logic [TIME_WIDTH-1:0]       r_upper_limit;
    logic                        r_expired_flag;

    logic                        r_out_valid;
    logic                        r_fired;
    logic                        r_expired;
    logic                        r_running;

    logic [TIME_WIDTH-1:0]       n_interval_len;
    logic [TIME_WIDTH-1:0]       n_trigger_time;
    logic [TIME_WIDTH-1:0]       n_upper_limit;
    logic                        n_expired_flag;
    logic                        n_fired;
    logic                        n_expired;

    logic                        advance;
    logic [TIME_WIDTH-1:0]       now_t;
    logic [TIME_WIDTH-1:0]       delay_t;
    logic [TIME_WIDTH-1:0]       len_sel;
    logic [TIME_WIDTH:0]         sum;
    logic                        wrap;
    logic [TIME_WIDTH-1:0]       trig_new;
    logic [TIME_WIDTH-1:0]       upper_new;
    logic                        hit;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = i_rst_n && (!r_in_valid || advance);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(ivt_pkg::OUT_TDATA_W - 3)'(0), r_running, r_expired, r_fired};

    assign now_t   = TIME_WIDTH'(r_now_ms);
    assign delay_t = TIME_WIDTH'(r_delay_ms);

    assign len_sel   = (r_action == ivt_pkg::ACT_START) ? delay_t : r_interval_len;
    assign sum       = {1'b0, now_t} + {1'b0, len_sel};
    assign wrap      = sum[TIME_WIDTH];
    assign trig_new  = wrap ? sum[TIME_WIDTH-1:0] : sum[TIME_WIDTH-1:0] - 1'b1;
    assign upper_new = wrap ? now_t : '1;

    assign hit = (r_interval_len != '0) && (r_trigger_time < now_t)
                 && (now_t < r_upper_limit);

    always_comb begin
        n_interval_len = r_interval_len;
        n_trigger_time = r_trigger_time;
        n_upper_limit  = r_upper_limit;
        n_expired_flag = r_expired_flag;
        n_fired        = 1'b0;
        n_expired      = 1'b0;
        unique case (r_action) inside
            ivt_pkg::ACT_TICK, ivt_pkg::ACT_POLL: begin
                if (hit) begin
                    n_fired        = 1'b1;
                    n_expired_flag = 1'b1;
                    if (r_recurring) begin
                        n_trigger_time = trig_new;
                        n_upper_limit  = upper_new;
                    end else begin
                        n_interval_len = '0;
                    end
                end
                if (r_action == ivt_pkg::ACT_POLL) begin
                    n_expired      = r_expired_flag || hit;
                    n_expired_flag = 1'b0;
                end
            end
            ivt_pkg::ACT_START: begin
                n_interval_len = delay_t;
                if (delay_t != '0) begin
                    n_trigger_time = trig_new;
                    n_upper_limit  = upper_new;
                end else begin
                    n_expired_flag = 1'b0;
                end
            end
            ivt_pkg::ACT_RESTART: begin
                if (r_interval_len != '0) begin
                    n_trigger_time = trig_new;
                    n_upper_limit  = upper_new;
                end
            end
            ivt_pkg::ACT_CANCEL: begin
                n_interval_len = '0;
                n_expired_flag = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_recurring <= i_cfg_wdata;
        end else if (!i_rst_n) begin
            r_recurring <= 1'b0;
        end
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_interval_len <= '0;
            r_trigger_time <= '0;
            r_upper_limit  <= '1;
            r_expired_flag <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_interval_len <= n_interval_len;
                    r_trigger_time <= n_trigger_time;
                    r_upper_limit  <= n_upper_limit;
                    r_expired_flag <= n_expired_flag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_action   <= ivt_pkg::t_action'(
                i_s_tdata[ivt_pkg::ACTION_LSB +: ivt_pkg::ACTION_W]);
            r_now_ms   <= i_s_tdata[ivt_pkg::NOW_LSB +: ivt_pkg::MS_W];
            r_delay_ms <= i_s_tdata[ivt_pkg::DELAY_LSB +: ivt_pkg::MS_W];
        end
        if (advance && r_in_valid) begin
            r_fired   <= n_fired;
            r_expired <= n_expired;
            r_running <= (n_interval_len != '0);
        end
    end

endmodule
`default_nettype wire

// File: src/ivt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer checker
// Port-level checks on the interval timer, bound to its top level.
// ----------------------------------------------------------------------------
module ivt_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,
    input  wire logic                            o_s_tready,
    input  wire logic                            o_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [ivt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic r_recurring;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_recurring <= i_cfg_wdata;
        end else if (!i_rst_n) begin
            r_recurring <= 1'b0;
        end
    end

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // The input side only waits while a result is pending.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // On expiry a recurring timer keeps running and a one-shot timer stops.
    a_fire_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[ivt_pkg::FIRED_BIT]
        |-> o_m_tdata[ivt_pkg::RUNNING_BIT] == r_recurring)
        else $error("running flag after expiry does not match mode");

    // Unused result bits stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[ivt_pkg::OUT_TDATA_W-1:ivt_pkg::RUNNING_BIT+1] == '0)
        else $error("unused result bits not zero");

endmodule

bind interval_timer_with_wrap ivt_checker u_ivt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);
`default_nettype wire
